// ----- rtl/core/fumc_pkg.sv -----
`timescale 1ns / 1ps

package fumc_pkg;

    localparam int FRAME_LEN = 8;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int TX_IDX_W  = $clog2(FRAME_LEN);

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h02;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'h03;

    // Operation codes of an input item.
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PARSER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE      = 2'd2;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_TX    = 2'd2
    } t_kind;

    typedef struct packed {
        logic  parser_enable;
        t_byte start_byte;
        t_byte end_byte;
    } t_cfg;

    typedef struct packed {
        logic  operation;
        t_byte rx_byte;
        t_byte tx_command;
        t_byte tx_arg1;
        t_byte tx_arg2;
        t_byte tx_arg3;
        t_byte tx_arg4;
    } t_in_item;

    typedef struct packed {
        t_kind kind;
        t_byte frame_command;
        t_byte frame_arg1;
        t_byte frame_arg2;
        t_byte frame_arg3;
        t_byte frame_arg4;
        t_byte tx_byte;
        logic  last;
    } t_out_item;

    // Wrapping 8-bit sum over the command and the four argument bytes.
    function automatic t_byte frame_sum(t_byte c, t_byte a1, t_byte a2, t_byte a3, t_byte a4);
        frame_sum = c + a1 + a2 + a3 + a4;
    endfunction

endpackage

// ----- rtl/core/fumc_in_if.sv -----
`timescale 1ns / 1ps

interface fumc_in_if;
    import fumc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/fumc_out_if.sv -----
`timescale 1ns / 1ps

interface fumc_out_if;
    import fumc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/fumc_rx_parser.sv -----
`timescale 1ns / 1ps

module fumc_rx_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fumc_pkg::t_cfg       i_cfg,
    input  logic                 i_take,
    input  fumc_pkg::t_byte      i_byte,
    output fumc_pkg::t_out_item  o_result
);
    import fumc_pkg::*;

    logic                r_receiving;
    logic [TX_IDX_W-1:0] r_count;
    t_byte               r_store [1:6];

    logic                n_receiving;
    logic [TX_IDX_W-1:0] n_count;
    logic                w_good;
    t_byte               w_sum;

    assign w_sum = frame_sum(r_store[1], r_store[2], r_store[3], r_store[4], r_store[5]);

    always_comb begin
        n_receiving = r_receiving;
        n_count     = r_count;
        w_good      = 1'b0;
        if (i_cfg.parser_enable) begin
            if (!r_receiving) begin
                if (i_byte == i_cfg.start_byte) begin
                    n_receiving = 1'b1;
                    n_count     = TX_IDX_W'(1);
                end
            end else begin
                n_count = r_count + TX_IDX_W'(1);
                // The byte at the last position closes the frame either way.
                if (r_count == TX_IDX_W'(FRAME_LEN - 1)) begin
                    n_receiving = 1'b0;
                    w_good      = (i_byte == i_cfg.end_byte) && (w_sum == r_store[6]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_count     <= '0;
        end else if (i_take) begin
            r_receiving <= n_receiving;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_cfg.parser_enable && r_receiving) begin
            for (int k = 1; k <= 6; k++) begin
                if (r_count == TX_IDX_W'(k)) begin
                    r_store[k] <= i_byte;
                end
            end
        end
    end

    always_comb begin
        o_result      = '0;
        o_result.kind = KIND_NONE;
        o_result.last = 1'b1;
        if (w_good) begin
            o_result.kind          = KIND_FRAME;
            o_result.frame_command = r_store[1];
            o_result.frame_arg1    = r_store[2];
            o_result.frame_arg2    = r_store[3];
            o_result.frame_arg3    = r_store[4];
            o_result.frame_arg4    = r_store[5];
        end
    end

endmodule

// ----- rtl/core/fumc_tx_framer.sv -----
`timescale 1ns / 1ps

module fumc_tx_framer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fumc_pkg::t_cfg       i_cfg,
    input  logic                 i_step,
    input  fumc_pkg::t_in_item   i_item,
    output fumc_pkg::t_out_item  o_result,
    output logic                 o_done
);
    import fumc_pkg::*;

    logic [TX_IDX_W-1:0] r_idx;
    t_byte               w_byte;

    assign o_done = (r_idx == TX_IDX_W'(FRAME_LEN - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_step) begin
            r_idx <= o_done ? '0 : r_idx + TX_IDX_W'(1);
        end
    end

    always_comb begin
        case (r_idx)
            3'd0:    w_byte = i_cfg.start_byte;
            3'd1:    w_byte = i_item.tx_command;
            3'd2:    w_byte = i_item.tx_arg1;
            3'd3:    w_byte = i_item.tx_arg2;
            3'd4:    w_byte = i_item.tx_arg3;
            3'd5:    w_byte = i_item.tx_arg4;
            3'd6:    w_byte = frame_sum(i_item.tx_command, i_item.tx_arg1, i_item.tx_arg2,
                                        i_item.tx_arg3, i_item.tx_arg4);
            default: w_byte = i_cfg.end_byte;
        endcase
    end

    always_comb begin
        o_result         = '0;
        o_result.kind    = KIND_TX;
        o_result.tx_byte = w_byte;
        o_result.last    = o_done;
    end

endmodule

// ----- rtl/core/framed_uart_message_codec.sv -----
`timescale 1ns / 1ps

// Framed UART message codec. Each input item is either one received byte or a request to
// send one frame; frames are start byte, command, four arguments, 8-bit wrapping sum of
// those five, end byte. A received byte yields exactly one result, which is a valid frame
// (kind 1) when the byte completes a frame whose end byte and checksum match, and kind 0
// otherwise. A send yields eight transmit-byte results, the last one flagged. Items pass
// through an input register and a result register. A received byte frees the input
// register as its result is registered; a send holds it while the framer's byte counter
// steps through all eight bytes. Received bytes flow at one item per cycle while the
// output is ready. An empty input register takes a new item while a result still waits
// on the output. Configuration is a plain write port (index 0 parser enable, 1 start
// byte, 2 end byte); changing the enable keeps any partial frame.
module framed_uart_message_codec (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fumc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  fumc_pkg::t_byte                i_cfg_data,
    fumc_in_if.sink                        i_in,
    fumc_out_if.source                     o_out
);
    import fumc_pkg::*;

    t_cfg      r_cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;

    logic      w_adv;
    logic      w_release;
    logic      w_accept;
    logic      w_tx_done;
    t_out_item w_rx_result;
    t_out_item w_tx_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.parser_enable <= 1'b0;
            r_cfg.start_byte    <= START_BYTE_RESET;
            r_cfg.end_byte      <= END_BYTE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PARSER_ENABLE: r_cfg.parser_enable <= i_cfg_data[0];
                CFG_START_BYTE:    r_cfg.start_byte    <= i_cfg_data;
                CFG_END_BYTE:      r_cfg.end_byte      <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // The held item produces one result each time the result register is free.
    assign w_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_release = w_adv && ((r_in.operation == OP_RX) || w_tx_done);
    assign i_in.ready = !r_in_valid || w_release;
    assign w_accept  = i_in.valid && i_in.ready;

    fumc_rx_parser u_rx_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_take   (w_adv && (r_in.operation == OP_RX)),
        .i_byte   (r_in.rx_byte),
        .o_result (w_rx_result)
    );

    fumc_tx_framer u_tx_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (w_adv && (r_in.operation == OP_SEND)),
        .i_item   (r_in),
        .o_result (w_tx_result),
        .o_done   (w_tx_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_release) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in.data;
        end
        if (w_adv) begin
            r_out <= (r_in.operation == OP_RX) ? w_rx_result : w_tx_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_frame_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.data.kind == KIND_FRAME) |-> o_out.data.last)
        else $error("received frame result not flagged last");

    a_none_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.data.kind == KIND_NONE)
        |-> (o_out.data.frame_command == '0) && (o_out.data.tx_byte == '0) && o_out.data.last)
        else $error("empty result carries data");

    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_in_valid)
        else $error("accepted item not held in input register");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out.valid)
        else $error("result register not loaded after advance");

endmodule

// ----- test/framed_uart_message_codec_test.sv -----
`timescale 1ns / 1ps

module framed_uart_message_codec_test;
    import fumc_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 20;
    localparam int STALL_PCT    = 11;

    // Index 3 decodes to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Tracks what the codec should produce: its registers, the receive parser state
    // and the queue of results still owed.
    class codec_scoreboard;
        logic       parse_on;
        t_byte      sof;
        t_byte      eof;
        bit         receiving;
        logic [3:0] byte_cnt;
        t_byte      store [FRAME_LEN];
        t_out_item  pending [$];
        int         errors;
        int         checked;
        int         frames_seen;

        function new();
            parse_on    = 1'b0;
            sof         = START_BYTE_RESET;
            eof         = END_BYTE_RESET;
            receiving   = 1'b0;
            byte_cnt    = '0;
            foreach (store[k]) store[k] = '0;
            errors      = 0;
            checked     = 0;
            frames_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, t_byte val);
            case (idx)
                CFG_PARSER_ENABLE: parse_on = val[0];
                CFG_START_BYTE:    sof = val;
                CFG_END_BYTE:      eof = val;
                default: ;
            endcase
        endfunction

        // Advances the parser by one received byte; returns 1 when a frame is complete
        // with a matching end marker and checksum.
        function bit parse_byte(t_byte b);
            bit    good;
            t_byte sum;
            good = 1'b0;
            if (!parse_on) return 1'b0;
            if (!receiving) begin
                if (b == sof) begin
                    store[0]  = b;
                    byte_cnt  = 4'd1;
                    receiving = 1'b1;
                end
                return 1'b0;
            end
            if (byte_cnt >= FRAME_LEN) begin
                receiving = 1'b0;
                return 1'b0;
            end
            store[byte_cnt[2:0]] = b;
            byte_cnt = byte_cnt + 4'd1;
            if (byte_cnt == FRAME_LEN) begin
                if (b == eof) begin
                    sum  = store[1] + store[2] + store[3] + store[4] + store[5];
                    good = (sum == store[6]);
                end
                receiving = 1'b0;
            end
            return good;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            t_byte     seq [FRAME_LEN];
            if (it.operation == OP_RX) begin
                r      = '0;
                r.kind = KIND_NONE;
                if (parse_byte(it.rx_byte)) begin
                    r.kind          = KIND_FRAME;
                    r.frame_command = store[1];
                    r.frame_arg1    = store[2];
                    r.frame_arg2    = store[3];
                    r.frame_arg3    = store[4];
                    r.frame_arg4    = store[5];
                    frames_seen++;
                end
                r.last = 1'b1;
                pending.push_back(r);
            end else begin
                seq[0] = sof;
                seq[1] = it.tx_command;
                seq[2] = it.tx_arg1;
                seq[3] = it.tx_arg2;
                seq[4] = it.tx_arg3;
                seq[5] = it.tx_arg4;
                seq[6] = seq[1] + seq[2] + seq[3] + seq[4] + seq[5];
                seq[7] = eof;
                for (int k = 0; k < FRAME_LEN; k++) begin
                    r         = '0;
                    r.kind    = KIND_TX;
                    r.tx_byte = seq[k];
                    r.last    = (k == FRAME_LEN - 1);
                    pending.push_back(r);
                end
            end
        endfunction

        function string show(t_out_item r);
            return $sformatf("kind=%0d cmd=%h args=%h %h %h %h tx=%h last=%0b", r.kind,
                             r.frame_command, r.frame_arg1, r.frame_arg2, r.frame_arg3,
                             r.frame_arg4, r.tx_byte, r.last);
        endfunction

        function void flag(string detail);
            errors++;
            if (errors <= 10) $display("MISMATCH %s", detail);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            checked++;
            if (pending.size() == 0) begin
                flag({"unexpected result: ", show(got)});
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.frame_command !== want.frame_command ||
                got.frame_arg1 !== want.frame_arg1 || got.frame_arg2 !== want.frame_arg2 ||
                got.frame_arg3 !== want.frame_arg3 || got.frame_arg4 !== want.frame_arg4 ||
                got.tx_byte !== want.tx_byte || got.last !== want.last) begin
                flag({"expected ", show(want), " got ", show(got)});
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_byte                i_cfg_data;

    fumc_in_if  in_ch ();
    fumc_out_if out_ch ();

    framed_uart_message_codec u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    codec_scoreboard sb;
    bit relaxed;
    int cycle_count;
    int n_items;
    int n_sends;
    int n_writes;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
                 sb.pending.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check every transfer, and hold ready low now and then.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
            out_ch.ready <= relaxed || ($urandom_range(99) >= STALL_PCT);
        end
    end

    function automatic t_byte rnd_byte();
        return t_byte'($urandom_range(255));
    endfunction

    // Unused fields carry random values so that the block is seen to ignore them.
    function automatic t_in_item rx_item(t_byte b);
        logic [63:0] raw;
        t_in_item    it;
        raw          = {$urandom(), $urandom()};
        it           = raw[$bits(t_in_item)-1:0];
        it.operation = OP_RX;
        it.rx_byte   = b;
        return it;
    endfunction

    function automatic t_in_item send_item(t_byte c, t_byte a1, t_byte a2, t_byte a3,
                                           t_byte a4);
        logic [63:0] raw;
        t_in_item    it;
        raw           = {$urandom(), $urandom()};
        it            = raw[$bits(t_in_item)-1:0];
        it.operation  = OP_SEND;
        it.tx_command = c;
        it.tx_arg1    = a1;
        it.tx_arg2    = a2;
        it.tx_arg3    = a3;
        it.tx_arg4    = a4;
        return it;
    endfunction

    task automatic push_item(t_in_item it);
        while (!relaxed && $urandom_range(99) < STALL_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(it);
        n_items++;
        if (it.operation == OP_SEND) n_sends++;
    endtask

    task automatic push_send();
        push_item(send_item(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte()));
    endtask

    // One frame of received bytes, optionally corrupted, with sends mixed in between
    // its bytes at the given rate.
    task automatic push_frame(t_byte cmd, t_byte a1, t_byte a2, t_byte a3, t_byte a4,
                              bit bad_sum, bit bad_end, int send_pct);
        t_byte body [FRAME_LEN];
        body[0] = sb.sof;
        body[1] = cmd;
        body[2] = a1;
        body[3] = a2;
        body[4] = a3;
        body[5] = a4;
        body[6] = cmd + a1 + a2 + a3 + a4;
        body[7] = sb.eof;
        if (bad_sum) body[6] = body[6] ^ t_byte'($urandom_range(255, 1));
        if (bad_end) body[7] = body[7] ^ t_byte'($urandom_range(255, 1));
        for (int k = 0; k < FRAME_LEN; k++) begin
            if (k > 0 && $urandom_range(99) < send_pct) push_send();
            push_item(rx_item(body[k]));
        end
    endtask

    // Drops valid and lets every owed result come out before the block is touched.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_byte val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        n_writes++;
        @(posedge i_clk);
    endtask

    initial begin
        int    base;
        int    pick;
        int    flaw;
        t_byte mark;
        t_byte part [FRAME_LEN];

        sb       = new();
        relaxed  = 1'b0;
        n_items  = 0;
        n_sends  = 0;
        n_writes = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Parser is off after reset: a send still frames, a start byte is ignored.
        push_item(send_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        push_item(rx_item(START_BYTE_RESET));
        settle();
        write_reg(CFG_PARSER_ENABLE, 8'd1);
        // A stray byte while idle, a good frame whose sum wraps, a frame with a wrong
        // end marker, and an all-ones send.
        push_item(rx_item(8'h55));
        push_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 0);
        push_frame(8'h00, 8'h80, 8'h01, 8'h7F, 8'h00, 1'b0, 1'b1, 0);
        push_item(send_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

        for (int p = 0; p < 6; p++) begin
            settle();
            relaxed = (p == 2);
            case (p)
                0: begin
                    write_reg(CFG_START_BYTE, 8'h00);
                    write_reg(CFG_END_BYTE, 8'hFF);
                end
                1: begin
                    write_reg(CFG_START_BYTE, 8'hFF);
                    write_reg(CFG_END_BYTE, 8'h00);
                end
                2: begin
                    mark = rnd_byte();
                    write_reg(CFG_START_BYTE, mark);
                    write_reg(CFG_END_BYTE, mark);
                end
                4: begin
                    write_reg(CFG_START_BYTE, START_BYTE_RESET);
                    write_reg(CFG_END_BYTE, END_BYTE_RESET);
                end
                default: begin
                    write_reg(CFG_SPARE, rnd_byte());
                    write_reg(CFG_START_BYTE, rnd_byte());
                    write_reg(CFG_END_BYTE, rnd_byte());
                end
            endcase

            if (p == 4) begin
                // Turning the parser off in the middle of a frame must keep the partial
                // frame, so the remaining bytes still complete it afterwards.
                part[0] = sb.sof;
                for (int k = 1; k < 6; k++) part[k] = rnd_byte();
                part[6] = part[1] + part[2] + part[3] + part[4] + part[5];
                part[7] = sb.eof;
                for (int k = 0; k < 4; k++) push_item(rx_item(part[k]));
                settle();
                write_reg(CFG_PARSER_ENABLE, 8'd0);
                push_item(rx_item(sb.sof));
                push_item(rx_item(rnd_byte()));
                push_send();
                settle();
                write_reg(CFG_PARSER_ENABLE, 8'd1);
                for (int k = 4; k < FRAME_LEN; k++) push_item(rx_item(part[k]));
            end

            base = n_items;
            while (n_items - base < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    flaw = $urandom_range(99);
                    push_frame(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(),
                               flaw < 15, flaw >= 15 && flaw < 30, 10);
                end else if (pick < 75) begin
                    push_item(rx_item(rnd_byte()));
                end else if (pick < 88) begin
                    push_send();
                end else begin
                    // A start marker followed by too few bytes: the next received bytes are
                    // swallowed into this frame.
                    push_item(rx_item(sb.sof));
                    repeat ($urandom_range(6)) push_item(rx_item(rnd_byte()));
                end
            end
        end

        relaxed = 1'b0;
        settle();
        $display("Run covered %0d input items (%0d frame sends) and %0d register writes.",
                 n_items, n_sends, n_writes);
        $display("Checked %0d results, %0d good frames received, %0d mismatches.",
                 sb.checked, sb.frames_seen, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- framed_uart_message_codec.f -----
rtl/core/fumc_pkg.sv
rtl/core/fumc_in_if.sv
rtl/core/fumc_out_if.sv
rtl/core/fumc_rx_parser.sv
rtl/core/fumc_tx_framer.sv
rtl/core/framed_uart_message_codec.sv
test/framed_uart_message_codec_test.sv
